@@ src/sha1md_pkg.sv @@
// ============================================================================
// SHA-1 message digest package
// Shared codes, constants and controller/datapath interface types.
// ============================================================================
package sha1md_pkg;

    // Item function codes
    localparam logic [1:0] FUNC_ABSORB  = 2'd0;
    localparam logic [1:0] FUNC_FINISH  = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // Round groups of twenty rounds each
    localparam logic [1:0] STG_CH   = 2'd0;
    localparam logic [1:0] STG_PAR1 = 2'd1;
    localparam logic [1:0] STG_MAJ  = 2'd2;
    localparam logic [1:0] STG_PAR2 = 2'd3;

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hefcdab89;
    localparam logic [31:0] IV2 = 32'h98badcfe;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hc3d2e1f0;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] FILL_LAST  = 6'h3f;
    localparam logic [5:0] FILL_LEN   = 6'd56;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       absorb;     // place data byte, advance fill and bit count
        logic       pad;        // place pad byte, zero the words after it
        logic       len;        // write bit count into words 14 and 15
        logic       zero_low;   // zero words 0 to 13
        logic       init;       // load working words from the chain
        logic       round;      // run one round, advance the schedule
        logic       chain_add;  // fold working words into the chain
        logic       restart;    // return chain, count and fill to reset values
        logic       emit_load;  // load one digest word into the output register
        logic [2:0] emit_idx;
        logic [1:0] stage;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic fill_last;   // next data byte completes a block
        logic pos_ge56;    // no room left for the length in this block
        logic out_free;    // output register can take a word this cycle
    } dp_stat_t;

endpackage

@@ src/sha1md_ctrl.sv @@
// ============================================================================
// SHA-1 controller
// Sequences absorb, padding, the eighty rounds and digest emission.
// ============================================================================
module sha1md_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          func,
    output logic                in_stall,
    input  sha1md_pkg::dp_stat_t stat,
    output sha1md_pkg::dp_cmd_t  cmd
);
    import sha1md_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RND   = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_FZERO = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic [1:0] MODE_ABSORB = 2'd0;
    localparam logic [1:0] MODE_FIN1   = 2'd1;  // first of two padding blocks
    localparam logic [1:0] MODE_FIN2   = 2'd2;  // final padding block

    logic [2:0] state_reg, state_next;
    logic [6:0] rnd_reg, rnd_next;
    logic [1:0] mode_reg, mode_next;
    logic [2:0] idx_reg, idx_next;
    logic       in_accept;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.emit_idx = idx_reg;

        if (rnd_reg < 7'd20)
        begin
            cmd.stage = STG_CH;
        end
        else if (rnd_reg < 7'd40)
        begin
            cmd.stage = STG_PAR1;
        end
        else if (rnd_reg < 7'd60)
        begin
            cmd.stage = STG_MAJ;
        end
        else
        begin
            cmd.stage = STG_PAR2;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (func)
                        FUNC_ABSORB:
                        begin
                            cmd.absorb = 1'b1;
                            if (stat.fill_last)
                            begin
                                cmd.init   = 1'b1;
                                mode_next  = MODE_ABSORB;
                                rnd_next   = '0;
                                state_next = ST_RND;
                            end
                        end
                        FUNC_FINISH:
                        begin
                            cmd.pad    = 1'b1;
                            cmd.len    = !stat.pos_ge56;
                            cmd.init   = 1'b1;
                            mode_next  = stat.pos_ge56 ? MODE_FIN1 : MODE_FIN2;
                            rnd_next   = '0;
                            state_next = ST_RND;
                        end
                        FUNC_RESTART:
                        begin
                            cmd.restart = 1'b1;
                        end
                        default:
                        begin
                            // unused code: drop the item
                        end
                    endcase
                end
            end
            ST_RND:
            begin
                cmd.round = 1'b1;
                if (rnd_reg == ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
                else
                begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            ST_ADD:
            begin
                cmd.chain_add = 1'b1;
                unique case (mode_reg)
                    MODE_FIN1:
                    begin
                        state_next = ST_FZERO;
                    end
                    MODE_FIN2:
                    begin
                        idx_next   = '0;
                        state_next = ST_EMIT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_FZERO:
            begin
                cmd.zero_low = 1'b1;
                cmd.len      = 1'b1;
                cmd.init     = 1'b1;
                mode_next    = MODE_FIN2;
                rnd_next     = '0;
                state_next   = ST_RND;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (idx_reg == WORD_LAST)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            mode_reg  <= MODE_ABSORB;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

@@ src/sha1md_dp.sv @@
// ============================================================================
// SHA-1 datapath
// Block buffer with in-place schedule, round logic, chain and output register.
// ============================================================================
module sha1md_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha1md_pkg::dp_cmd_t  cmd,
    input  logic [7:0]           data_byte,
    input  logic                 out_stall,
    output sha1md_pkg::dp_stat_t stat,
    output logic                 out_valid,
    output logic [31:0]          digest_word,
    output logic [2:0]           word_index,
    output logic                 last
);
    import sha1md_pkg::*;

    logic [31:0] blk_reg   [16];
    logic [31:0] blk_next  [16];
    logic [31:0] chain_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [63:0] bit_total_reg;
    logic [5:0]  fill_reg;
    logic        out_valid_reg;
    logic [31:0] word_reg;
    logic [2:0]  index_reg;
    logic        last_reg;

    logic [7:0]  byte_val;
    logic [3:0]  widx;
    logic [31:0] byte_word;
    logic [31:0] w_mix;
    logic [31:0] w_new;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;

    assign stat.fill_last = (fill_reg == FILL_LAST);
    assign stat.pos_ge56  = (fill_reg >= FILL_LEN);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // Next schedule word: XOR of the four taps, rotated left by one
    assign w_mix = blk_reg[13] ^ blk_reg[8] ^ blk_reg[2] ^ blk_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb
    begin
        case (cmd.stage)
            STG_CH:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = K0;
            end
            STG_PAR1:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K1;
            end
            STG_MAJ:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = K2;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = K3;
            end
        endcase
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + blk_reg[0] + k_val;

    // Block buffer update: byte insert, padding, zeroing, length, or schedule shift
    always_comb
    begin
        byte_val  = cmd.pad ? PAD_BYTE : data_byte;
        widx      = fill_reg[5:2];
        byte_word = {byte_val, 24'h000000} >> {fill_reg[1:0], 3'b000};
        for (int i = 0; i < 16; i++)
        begin
            blk_next[i] = blk_reg[i];
        end
        if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                blk_next[i] = blk_reg[i + 1];
            end
            blk_next[15] = w_new;
        end
        else
        begin
            if (cmd.absorb || cmd.pad)
            begin
                // first byte of a word overwrites the whole word
                if (fill_reg[1:0] == 2'd0)
                begin
                    blk_next[widx] = byte_word;
                end
                else
                begin
                    blk_next[widx] = blk_reg[widx] | byte_word;
                end
            end
            if (cmd.pad)
            begin
                for (int i = 0; i < 16; i++)
                begin
                    if (4'(i) > widx)
                    begin
                        blk_next[i] = '0;
                    end
                end
            end
            if (cmd.zero_low)
            begin
                for (int i = 0; i < 14; i++)
                begin
                    blk_next[i] = '0;
                end
            end
            if (cmd.len)
            begin
                blk_next[14] = bit_total_reg[63:32];
                blk_next[15] = bit_total_reg[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            blk_reg[i] <= blk_next[i];
        end
    end

    // Working words
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (cmd.round)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Chain, bit count and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0]  <= IV0;
            chain_reg[1]  <= IV1;
            chain_reg[2]  <= IV2;
            chain_reg[3]  <= IV3;
            chain_reg[4]  <= IV4;
            bit_total_reg <= '0;
            fill_reg      <= '0;
        end
        else if (cmd.restart)
        begin
            chain_reg[0]  <= IV0;
            chain_reg[1]  <= IV1;
            chain_reg[2]  <= IV2;
            chain_reg[3]  <= IV3;
            chain_reg[4]  <= IV4;
            bit_total_reg <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            if (cmd.chain_add)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
            if (cmd.absorb)
            begin
                bit_total_reg <= bit_total_reg + 64'd8;
                fill_reg      <= fill_reg + 6'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            word_reg  <= chain_reg[cmd.emit_idx];
            index_reg <= cmd.emit_idx;
            last_reg  <= (cmd.emit_idx == WORD_LAST);
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = word_reg;
    assign word_index  = index_reg;
    assign last        = last_reg;

endmodule

@@ src/sha1_message_digest.sv @@
// ============================================================================
// SHA-1 message digest engine
// Byte-wide SHA-1 hash with padding and five-word digest output.
// ============================================================================
// Each input item carries a function code: absorb one message byte, finish
// the message, or restart the hash (code 3 is dropped). An absorb does not
// stall the input, except that the 64th byte of a block starts the
// compression: 80 rounds at one round per cycle, then a fold of the result
// into the chain, with the input stalled until the fold is done. The single
// round unit and the 16-word block buffer, which doubles as the message
// schedule, carry out the compression. A finish item pads the message and
// runs one compression, or two when fewer than 9 bytes of room remain in
// the block, then emits the five digest words H0 to H4, one per cycle as
// the output side takes them, with last set on the fifth. The hash state
// returns to its initial values once the fifth word is loaded, and the
// next item is taken while that word still waits in the output register.
// ============================================================================
module sha1_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last
);
    import sha1md_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller: accepts items in idle and steps rounds and emission
    sha1md_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: block buffer, round unit, chain, bit count and output register
    sha1md_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .out_stall   (out_stall),
        .stat        (stat),
        .out_valid   (out_valid),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last        (last)
    );

endmodule

@@ src/sha1md_check.sv @@
// ============================================================================
// SHA-1 port checker
// Port-level assertions, bound to the top level.
// ============================================================================
module sha1md_check (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  func,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last
);
    import sha1md_pkg::*;

    // A stalled result stays valid
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(digest_word) && $stable(word_index)
                                   && $stable(last))
        else $error("result changed while stalled");

    // Last marks the fifth word only
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (word_index == WORD_LAST)))
        else $error("last flag does not match word index");

    // A finish item always starts a compression
    a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func == FUNC_FINISH |=> in_stall)
        else $error("input not stalled after finish");

    // Input stays stalled until the final digest word is loaded
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && word_index != WORD_LAST |-> in_stall)
        else $error("input taken during digest emission");

endmodule

bind sha1_message_digest sha1md_check u_check (.*);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams byte messages through the hash engine with random idle bursts on
// the input and output sides. A behavioral SHA-1 tracker predicts every
// digest word, and each word the engine delivers is checked against it.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1md_pkg::*;

    // Code 3 is not a function; the engine must drop it.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Stimulus budget: counted items, and the point where idling stops.
    localparam int ITEM_TARGET = 280;
    localparam int QUIET_AFTER = 230;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        bit [31:0] word;
        bit [2:0]  index;
        bit        last;
    } digest_word_t;

    // ------------------------------------------------------------------------
    // Digest tracker: keeps its own hash state, predicts the digest words
    // that each accepted item causes and checks the words the engine emits.
    // ------------------------------------------------------------------------
    class digest_tracker;
        bit [31:0]    hash_state[5];
        bit [63:0]    msg_bits;
        bit [31:0]    msg_block[16];
        bit [5:0]     byte_pos;
        digest_word_t expected_digest[$];
        int unsigned  failures;

        function new();
            foreach (msg_block[i]) msg_block[i] = '0;
            failures = 0;
            restart();
        endfunction

        function void restart();
            hash_state[0] = IV0;
            hash_state[1] = IV1;
            hash_state[2] = IV2;
            hash_state[3] = IV3;
            hash_state[4] = IV4;
            msg_bits = '0;
            byte_pos = '0;
        endfunction

        function bit [31:0] rotl(bit [31:0] x, int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        // Run the 80 rounds over msg_block and fold into hash_state.
        function void run_rounds();
            bit [31:0] w[80];
            bit [31:0] a, b, c, d, e, f, k, t;
            for (int r = 0; r < 16; r++) w[r] = msg_block[r];
            for (int r = 16; r < 80; r++)
                w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
            a = hash_state[0];
            b = hash_state[1];
            c = hash_state[2];
            d = hash_state[3];
            e = hash_state[4];
            for (int r = 0; r < 80; r++)
            begin
                if (r < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = K0;
                end
                else if (r < 40)
                begin
                    f = b ^ c ^ d;
                    k = K1;
                end
                else if (r < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K2;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = K3;
                end
                t = rotl(a, 5) + f + e + w[r] + k;
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = t;
            end
            hash_state[0] += a;
            hash_state[1] += b;
            hash_state[2] += c;
            hash_state[3] += d;
            hash_state[4] += e;
        endfunction

        // Big-endian placement; the first byte of a word clears the word.
        function void put_byte(bit [7:0] value);
            int sh;
            sh = 24 - 8 * byte_pos[1:0];
            if (byte_pos[1:0] == 2'd0)
                msg_block[byte_pos[5:2]] = 32'(value) << sh;
            else
                msg_block[byte_pos[5:2]] |= 32'(value) << sh;
            byte_pos = byte_pos + 6'd1;
        endfunction

        function void take_item(bit [1:0] func, bit [7:0] value);
            bit [5:0] pos;
            case (func)
                FUNC_ABSORB:
                begin
                    msg_bits += 64'd8;
                    put_byte(value);
                    if (byte_pos == '0) run_rounds();
                end
                FUNC_RESTART: restart();
                FUNC_FINISH:
                begin
                    pos = byte_pos;
                    put_byte(PAD_BYTE);
                    for (int i = pos[5:2] + 1; i < 16; i++) msg_block[i] = '0;
                    // No room for the length: spill into a second block.
                    if (pos >= FILL_LEN)
                    begin
                        run_rounds();
                        for (int i = 0; i < 14; i++) msg_block[i] = '0;
                    end
                    msg_block[14] = msg_bits[63:32];
                    msg_block[15] = msg_bits[31:0];
                    run_rounds();
                    for (int i = 0; i < 5; i++)
                        expected_digest.push_back('{hash_state[i], 3'(i),
                                                    3'(i) == WORD_LAST});
                    restart();
                end
                default: ;
            endcase
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= REPORT_LIMIT) $display("%t %s", $realtime, msg);
        endfunction

        function void check_digest_word(bit [31:0] word, bit [2:0] index, bit last);
            digest_word_t want;
            if (expected_digest.size() == 0)
            begin
                note_failure($sformatf("unexpected digest word %h index %0d last %0b",
                                       word, index, last));
                return;
            end
            want = expected_digest.pop_front();
            if (word !== want.word || index !== want.index || last !== want.last)
                note_failure($sformatf(
                    "digest word differs: expected %h/%0d/%0b, got %h/%0d/%0b",
                    want.word, want.index, want.last, word, index, last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = FUNC_ABSORB;
    logic [7:0]  data_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    digest_tracker tracker;
    int  items_sent = 0;
    bit  quiet = 1'b0;

    sha1_message_digest dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("sha1_message_digest: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input side. Called just after a rising edge. Optionally hold the
    // channel idle for a burst (junk on the payload while idle), then present
    // the item and hold it until the engine stops stalling.
    // ------------------------------------------------------------------------
    task automatic send_item(logic [1:0] code, logic [7:0] value);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid  <= 1'b0;
            func      <= 2'($urandom);
            data_byte <= 8'($urandom);
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= code;
        data_byte <= value;
        do @(posedge clk); while (in_stall);
        tracker.take_item(code, value);
        if (code != FUNC_UNUSED) items_sent++;
        if (items_sent >= QUIET_AFTER) quiet = 1'b1;
    endtask

    task automatic send_text(string text);
        for (int i = 0; i < text.len(); i++) send_item(FUNC_ABSORB, text[i]);
    endtask

    // One random message. Lengths cluster where padding changes shape:
    // short tails, the 55/56 byte boundary, whole blocks and two-block
    // messages. Now and then drop in an unused code, and sometimes abandon
    // the message with a restart instead of finishing it.
    task automatic send_message();
        int sel;
        int len;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            len = $urandom_range(0, 12);
        else if (sel < 8)
            len = $urandom_range(52, 70);
        else if (sel < 9)
            len = $urandom_range(118, 130);
        else
            len = $urandom_range(13, 51);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                send_item(FUNC_UNUSED, 8'($urandom));
            send_item(FUNC_ABSORB, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) == 0)
            send_item(FUNC_RESTART, 8'($urandom));
        else
            send_item(FUNC_FINISH, 8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Output side: alternate stall bursts and open stretches; stop stalling
    // once the run enters its quiet tail.
    // ------------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (quiet || $urandom_range(0, 1) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Check every digest word the engine hands over.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_digest_word(digest_word, word_index, last);
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty message, then an unused code that must change nothing.
        send_item(FUNC_FINISH, 8'hff);
        send_item(FUNC_UNUSED, 8'hff);
        // The classic three-byte message.
        send_text("abc");
        send_item(FUNC_FINISH, 8'h00);
        // Restart mid-message: only the bytes after it count.
        send_item(FUNC_ABSORB, 8'h00);
        send_item(FUNC_ABSORB, 8'hff);
        send_item(FUNC_RESTART, 8'h00);
        send_item(FUNC_ABSORB, 8'h5a);
        send_item(FUNC_FINISH, 8'h5a);
        // Extreme bytes around an unused code inside a partial word.
        send_item(FUNC_ABSORB, 8'hff);
        send_item(FUNC_UNUSED, 8'h00);
        send_item(FUNC_ABSORB, 8'h00);
        send_item(FUNC_ABSORB, 8'hff);
        send_item(FUNC_FINISH, 8'h00);
        // Restart with nothing absorbed, then finish empty again.
        send_item(FUNC_RESTART, 8'hff);
        send_item(FUNC_FINISH, 8'h00);

        // Random messages until the item budget is spent.
        while (items_sent < ITEM_TARGET) send_message();
        in_valid <= 1'b0;

        // Drain outstanding digest words, then give a trailing compression
        // time to surface any stray output.
        while (tracker.expected_digest.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.failures == 0)
            $display("sha1_message_digest: match");
        else
            $display("sha1_message_digest: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
src/sha1md_pkg.sv
src/sha1md_ctrl.sv
src/sha1md_dp.sv
src/sha1_message_digest.sv
src/sha1md_check.sv
test/tb_top.sv
